### design/gradient_colormap_lookup_macros.svh
// ----------------------------------------------------------------------------
// Gradient colormap lookup assertion macros
// Shared concurrent assertion forms for the colormap lookup block.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_COLORMAP_LOOKUP_MACROS_SVH
`define GRADIENT_COLORMAP_LOOKUP_MACROS_SVH

// same-cycle implication
`define GCL_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// next-cycle implication
`define GCL_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

### design/gcl_pkg.sv
// ----------------------------------------------------------------------------
// Gradient colormap lookup package
// Sizes, register indexes, mode codes and shared types.
// ----------------------------------------------------------------------------
package gcl_pkg;

   localparam int MAX_STOPS = 16;
   localparam int IDX_W     = $clog2(MAX_STOPS);
   localparam int CNT_W     = 5;
   localparam int POS_W     = 18;
   localparam int DIST_W    = 17;
   localparam int NUM_W     = 25;
   localparam int COLOR_W   = 32;
   localparam int QDEPTH    = 2;
   localparam int QPTR_W    = 1;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 2'd1;

   localparam logic [1:0] MODE_CLIP    = 2'd0;
   localparam logic [1:0] MODE_REPEAT  = 2'd1;
   localparam logic [1:0] MODE_MIRROR  = 2'd2;
   localparam logic [1:0] MODE_DIVERGE = 2'd3;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_MAP   = 1'b1;

   typedef struct packed {
      logic                 is_write;
      logic                 lerp;
      logic [IDX_W-1:0]     left;
      logic [IDX_W-1:0]     right;
      logic [DIST_W-1:0]    span;
      logic [DIST_W-1:0]    offs;
      logic [COLOR_W-1:0]   color;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } back_state_type;

endpackage

### design/gradient_colormap_lookup.sv
// ----------------------------------------------------------------------------
// Gradient colormap lookup
// Piecewise-linear RGBA colormap over up to sixteen gradient stops.
// ----------------------------------------------------------------------------
// Requests enter through req_push/req_full. An opcode 0 request writes one
// stop (position and RGBA); an opcode 1 request maps req_sample and yields
// one response on rsp_red..rsp_alpha, taken with rsp_pop while rsp_empty is
// low. Stops must be written in ascending position order by software.
// csr_we/csr_index/csr_data set the mapping mode (index 0) and the stop
// count (index 1); the user must write them only while the block is idle,
// which the block itself does not enforce. A mapped sample passes from the
// queue through the stop-color RAM read and the MUL state to the response
// register; an interpolated one (not at an end stop or between equal stops)
// also runs the 8-step restoring divider in the back end. The back end takes
// one command at a time; a two-entry queue lets the front keep accepting.
// Reset sets clip mode and a stop count of one and empties the queue; stop
// tables hold garbage until written. A stalled receiver holds the response
// register, the back end then stops, and req_full rises once the queue fills.
// ----------------------------------------------------------------------------
module gradient_colormap_lookup (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [gcl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gcl_pkg::CSR_DAT_W-1:0] csr_data,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_opcode,
   input  logic [3:0]                    req_stop_index,
   input  logic signed [15:0]            req_stop_position,
   input  logic [7:0]                    req_stop_red,
   input  logic [7:0]                    req_stop_green,
   input  logic [7:0]                    req_stop_blue,
   input  logic [7:0]                    req_stop_alpha,
   input  logic signed [15:0]            req_sample,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [7:0]                    rsp_red,
   output logic [7:0]                    rsp_green,
   output logic [7:0]                    rsp_blue,
   output logic [7:0]                    rsp_alpha
);
   import gcl_pkg::*;

   cmd_type cmd, head;
   logic    accept, q_pop, q_empty;

   assign accept = req_push & ~req_full;

   gcl_front u_front (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .accept(accept), .opcode(req_opcode), .stop_index(req_stop_index),
      .stop_position(req_stop_position), .stop_red(req_stop_red),
      .stop_green(req_stop_green), .stop_blue(req_stop_blue),
      .stop_alpha(req_stop_alpha), .sample(req_sample), .cmd(cmd)
   );

   gcl_queue u_queue (
      .clock(clock), .reset(reset), .push(req_push), .push_cmd(cmd),
      .pop(q_pop), .head(head), .full(req_full), .empty(q_empty)
   );

   gcl_back u_back (
      .clock(clock), .reset(reset), .head(head), .q_empty(q_empty),
      .q_pop(q_pop), .rsp_pop(rsp_pop), .rsp_empty(rsp_empty),
      .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue),
      .rsp_alpha(rsp_alpha)
   );
endmodule

### design/gcl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gcl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### design/gcl_front.sv
// ----------------------------------------------------------------------------
// Colormap lookup front end
// Holds configuration and stop positions, maps samples and brackets them.
// ----------------------------------------------------------------------------
module gcl_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [gcl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gcl_pkg::CSR_DAT_W-1:0] csr_data,
   input  logic                       accept,
   input  logic                       opcode,
   input  logic [3:0]                 stop_index,
   input  logic signed [15:0]         stop_position,
   input  logic [7:0]                 stop_red,
   input  logic [7:0]                 stop_green,
   input  logic [7:0]                 stop_blue,
   input  logic [7:0]                 stop_alpha,
   input  logic signed [15:0]         sample,
   output gcl_pkg::cmd_type           cmd
);
   import gcl_pkg::*;

   logic [1:0]       mode_ff, mode_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      pos_ff [MAX_STOPS];

   logic [CNT_W-1:0]        n;
   logic [IDX_W-1:0]        last;
   logic signed [POS_W-1:0] s;
   logic signed [POS_W-1:0] p [MAX_STOPS];
   logic [MAX_STOPS-1:0]    gt, above;
   logic [IDX_W-1:0]        r, l;
   logic signed [POS_W-1:0] pl, pr;
   logic signed [POS_W:0]   d, t;
   logic signed [16:0]      v, av;

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      if (csr_we && csr_index == CSR_MODE) begin
         mode_in = csr_data[1:0];
      end
      if (csr_we && csr_index == CSR_COUNT) begin
         count_in = csr_data[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_CLIP;
         count_ff <= CNT_W'(1);
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && opcode == OP_WRITE && {1'b0, stop_index} < 5'(MAX_STOPS)) begin
         pos_ff[stop_index[IDX_W-1:0]] <= stop_position;
      end
   end

   always_comb begin
      if (count_ff == '0) begin
         n = CNT_W'(1);
      end else if (count_ff > CNT_W'(MAX_STOPS)) begin
         n = CNT_W'(MAX_STOPS);
      end else begin
         n = count_ff;
      end
      last = IDX_W'(n - CNT_W'(1));
   end

   always_comb begin
      v  = {sample[15], sample};
      av = v[16] ? -v : v;
      if (av > 17'sd32767) begin
         av = 17'sd32767;
      end
      case (mode_ff)
         MODE_REPEAT:  s = $signed({5'd0, sample[11:0], 1'b0});
         MODE_MIRROR:  s = $signed({av, 1'b0});
         MODE_DIVERGE: s = POS_W'(v) + POS_W'(4096);
         default:      s = $signed({v, 1'b0});
      endcase
   end

   always_comb begin
      for (int i = 0; i < MAX_STOPS; i++) begin
         p[i]     = $signed({pos_ff[i][15], pos_ff[i], 1'b0});
         gt[i]    = p[i] > s;
         above[i] = gt[i] && (CNT_W'(i) < n);
      end
   end

   always_comb begin
      r = last;
      for (int i = MAX_STOPS - 1; i >= 0; i--) begin
         if (above[i]) begin
            r = IDX_W'(i);
         end
      end
      l  = r - IDX_W'(1);
      pl = '0;
      pr = '0;
      for (int i = 0; i < MAX_STOPS; i++) begin
         if (IDX_W'(i) == l) begin
            pl = p[i];
         end
         if (IDX_W'(i) == r) begin
            pr = p[i];
         end
      end
      d = {pr[POS_W-1], pr} - {pl[POS_W-1], pl};
      t = {s[POS_W-1], s} - {pl[POS_W-1], pl};
   end

   always_comb begin
      cmd.is_write = (opcode == OP_WRITE);
      cmd.color    = {stop_alpha, stop_blue, stop_green, stop_red};
      cmd.span     = d[DIST_W-1:0];
      cmd.offs     = t[DIST_W-1:0];
      cmd.lerp     = 1'b0;
      cmd.right    = r;
      if (opcode == OP_WRITE) begin
         cmd.left = stop_index[IDX_W-1:0];
      end else if (n == CNT_W'(1) || s <= p[0]) begin
         cmd.left = '0;
      end else if (!gt[last]) begin
         cmd.left = last;
      end else if (d <= 0) begin
         cmd.left = r;
      end else begin
         cmd.left = l;
         cmd.lerp = 1'b1;
      end
   end
endmodule

### design/gcl_queue.sv
// ----------------------------------------------------------------------------
// Colormap lookup command queue
// Short queue between the front end and the back end.
// ----------------------------------------------------------------------------
module gcl_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  gcl_pkg::cmd_type push_cmd,
   input  logic             pop,
   output gcl_pkg::cmd_type head,
   output logic             full,
   output logic             empty
);
   import gcl_pkg::*;

   cmd_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;

   assign full  = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = (push && !full) ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = (pop && !empty) ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(pop && !empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end
endmodule

### design/gcl_back.sv
// ----------------------------------------------------------------------------
// Colormap lookup back end
// Owns stop colors, interpolates the channels and holds the result.
// ----------------------------------------------------------------------------
`include "gradient_colormap_lookup_macros.svh"

module gcl_back (
   input  logic             clock,
   input  logic             reset,
   input  gcl_pkg::cmd_type head,
   input  logic             q_empty,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_alpha
);
   import gcl_pkg::*;

   back_state_type state_ff, state_in;
   logic           ram_we, load_out;
   logic [COLOR_W-1:0] col_l, col_r;

   logic               lerp_ff;
   logic [DIST_W-1:0]  d_ff, t_ff;
   logic [2:0]         bit_ff;
   logic [NUM_W-1:0]   rem_ff [4];
   logic [7:0]         q_ff [4];
   logic [COLOR_W-1:0] res_ff;
   logic               valid_ff, valid_in;
   logic [COLOR_W-1:0] out_ff;

   logic signed [26:0] num [4];
   logic [NUM_W-1:0]   dsh;

   gcl_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_STOPS)) u_ram_l (
      .clock(clock), .we(ram_we), .waddr(head.left), .wdata(head.color),
      .raddr(head.left), .rdata(col_l)
   );

   gcl_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_STOPS)) u_ram_r (
      .clock(clock), .we(ram_we), .waddr(head.left), .wdata(head.color),
      .raddr(head.right), .rdata(col_r)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty && !head.is_write) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = lerp_ff ? ST_DIV : ST_OUT;
         ST_DIV: begin
            if (bit_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop    = 1'b0;
      ram_we   = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            q_pop  = !q_empty;
            ram_we = !q_empty && head.is_write;
         end
         ST_OUT:  load_out = !valid_ff || rsp_pop;
         default: ;
      endcase
   end

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         num[c] = $signed({19'd0, col_l[8*c +: 8]}) * $signed({10'd0, d_ff})
                + ($signed({19'd0, col_r[8*c +: 8]}) - $signed({19'd0, col_l[8*c +: 8]}))
                  * $signed({10'd0, t_ff});
      end
      dsh = NUM_W'(d_ff) << bit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            lerp_ff <= head.lerp;
            d_ff    <= head.span;
            t_ff    <= head.offs;
            bit_ff  <= 3'd7;
         end
         ST_MUL: begin
            res_ff <= col_l;
            for (int c = 0; c < 4; c++) begin
               rem_ff[c] <= (num[c] < 0) ? '0 : NUM_W'(num[c]);
               q_ff[c]   <= '0;
            end
         end
         ST_DIV: begin
            bit_ff <= bit_ff - 3'd1;
            for (int c = 0; c < 4; c++) begin
               if (rem_ff[c] >= dsh) begin
                  rem_ff[c]         <= rem_ff[c] - dsh;
                  q_ff[c][bit_ff]   <= 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   assign valid_in = load_out | (valid_ff & ~rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ff <= lerp_ff ? {q_ff[3], q_ff[2], q_ff[1], q_ff[0]} : res_ff;
      end
   end

   assign rsp_empty = ~valid_ff;
   assign rsp_red   = out_ff[7:0];
   assign rsp_green = out_ff[15:8];
   assign rsp_blue  = out_ff[23:16];
   assign rsp_alpha = out_ff[31:24];

   `GCL_ASSERT_IMP(a_pop_idle, clock, reset, q_pop, state_ff == ST_IDLE)
   `GCL_ASSERT_NEXT(a_load_valid, clock, reset, load_out, valid_ff)
   `GCL_ASSERT_IMP(a_div_lerp, clock, reset, state_ff == ST_DIV, lerp_ff)
   `GCL_ASSERT_NEXT(a_write_stays, clock, reset, ram_we, state_ff == ST_IDLE)
endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Gradient colormap lookup testbench
// Writes gradient stops and maps samples under every mapping mode and a
// range of stop counts, predicting each RGBA response in the bench and
// checking it against the block, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import gcl_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 24;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic                 req_opcode = 1'b0;
   logic [3:0]           req_stop_index = '0;
   logic signed [15:0]   req_stop_position = '0;
   logic [7:0]           req_stop_red = '0;
   logic [7:0]           req_stop_green = '0;
   logic [7:0]           req_stop_blue = '0;
   logic [7:0]           req_stop_alpha = '0;
   logic signed [15:0]   req_sample = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [7:0]           rsp_red, rsp_green, rsp_blue, rsp_alpha;

   gradient_colormap_lookup uut (.*);

   always #6 clock = ~clock;

   // predictor state
   logic [1:0]         cur_mode = MODE_CLIP;
   logic [4:0]         cur_count = 5'd1;
   logic signed [15:0] stop_pos_tab [MAX_STOPS];
   logic [31:0]        stop_rgba_tab [MAX_STOPS];
   logic [31:0]        pending_colors [$];

   int  error_count = 0;
   int  maps_sent = 0, writes_sent = 0, colors_checked = 0;
   int  idle_cycles = 0;
   bit  push_high = 0;
   int  burst_left = 0;

   function automatic int stop_pos2(int i);
      return int'(stop_pos_tab[i]) * 2;
   endfunction

   function automatic logic [31:0] predict_color(logic signed [15:0] smp);
      int n, s, v, r, lft, pl, pr;
      longint d, t, a, b, num, q;
      logic [31:0] res;
      n = cur_count;
      if (n == 0) n = 1;
      if (n > MAX_STOPS) n = MAX_STOPS;
      v = int'(smp);
      case (cur_mode)
         MODE_REPEAT: s = int'({20'd0, smp[11:0]}) * 2;
         MODE_MIRROR: begin
            if (v < 0) v = -v;
            if (v > 32767) v = 32767;
            s = v * 2;
         end
         MODE_DIVERGE: s = v + 4096;
         default: s = v * 2;
      endcase
      if (n == 1 || s <= stop_pos2(0)) return stop_rgba_tab[0];
      if (s >= stop_pos2(n - 1)) return stop_rgba_tab[n - 1];
      r = n - 1;
      for (int i = 0; i < n; i++) begin
         if (stop_pos2(i) > s) begin
            r = i;
            break;
         end
      end
      lft = r - 1;
      pl = stop_pos2(lft);
      pr = stop_pos2(r);
      d = pr - pl;
      t = s - pl;
      if (d <= 0) return stop_rgba_tab[r];
      for (int ch = 0; ch < 4; ch++) begin
         a = stop_rgba_tab[lft][8*ch +: 8];
         b = stop_rgba_tab[r][8*ch +: 8];
         num = a * d + (b - a) * t;
         if (num < 0) num = 0;
         q = num / d;
         if (q > 255) q = 255;
         res[8*ch +: 8] = q[7:0];
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   // response checker
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_colors.size() == 0) begin
            report_mismatch("unexpected response", rsp_red, 8'd0);
         end else begin
            want = pending_colors.pop_front();
            colors_checked++;
            if (rsp_red   !== want[7:0])   report_mismatch("red",   rsp_red,   want[7:0]);
            if (rsp_green !== want[15:8])  report_mismatch("green", rsp_green, want[15:8]);
            if (rsp_blue  !== want[23:16]) report_mismatch("blue",  rsp_blue,  want[23:16]);
            if (rsp_alpha !== want[31:24]) report_mismatch("alpha", rsp_alpha, want[31:24]);
         end
      end
   end

   // receiver stall pattern
   int pop_phase = 0, pop_left = 0;
   always @(posedge clock) begin
      if (pop_left == 0) begin
         pop_phase = $urandom_range(0, 3);
         pop_left = (pop_phase == 2) ? $urandom_range(1, 20) : $urandom_range(5, 60);
      end
      pop_left--;
      case (pop_phase)
         0, 3: rsp_pop <= 1'b1;
         1: rsp_pop <= 1'($urandom_range(0, 1));
         default: rsp_pop <= 1'b0;
      endcase
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("gradient_colormap_lookup verification failed");
         $finish;
      end
   end

   task automatic send_request(logic op, logic [3:0] idx, logic signed [15:0] pos,
                               logic [31:0] rgba, logic signed [15:0] smp);
      req_opcode <= op;
      req_stop_index <= idx;
      req_stop_position <= pos;
      {req_stop_alpha, req_stop_blue, req_stop_green, req_stop_red} <= rgba;
      req_sample <= smp;
      req_push <= 1'b1;
      push_high = 1;
      do @(posedge clock); while (req_full);
      if (op == OP_WRITE) begin
         stop_pos_tab[idx] = pos;
         stop_rgba_tab[idx] = rgba;
         writes_sent++;
      end else begin
         pending_colors.insert(pending_colors.size(), predict_color(smp));
         maps_sent++;
      end
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 3) != 0) begin
            req_push <= 1'b0;
            push_high = 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   task automatic write_stop(int idx, int pos, logic [31:0] rgba);
      send_request(OP_WRITE, idx[3:0], pos[15:0], rgba, 16'($urandom()));
   endtask

   task automatic map_sample(int smp);
      send_request(OP_MAP, 4'($urandom()), 16'($urandom()), $urandom(), smp[15:0]);
   endtask

   task automatic wait_drained();
      if (push_high) begin
         req_push <= 1'b0;
         push_high = 0;
         @(posedge clock);
      end
      while (pending_colors.size() != 0) @(posedge clock);
   endtask

   task automatic configure(logic [1:0] mode, logic [4:0] count, bit poke_unknown);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_MODE;
      csr_data <= {3'b111, mode};
      @(posedge clock);
      cur_mode = mode;
      csr_index <= CSR_COUNT;
      csr_data <= count;
      @(posedge clock);
      cur_count = count;
      if (poke_unknown) begin
         csr_index <= CSR_IDX_W'(2);
         csr_data <= CSR_DAT_W'($urandom());
         @(posedge clock);
         csr_index <= CSR_IDX_W'(3);
         csr_data <= CSR_DAT_W'($urandom());
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic load_sorted_table(int lo, int hi);
      int pos_list [$];
      for (int i = 0; i < MAX_STOPS; i++)
         pos_list.insert(pos_list.size(), $urandom_range(lo, hi) - 32768);
      pos_list.sort();
      for (int i = 0; i < MAX_STOPS; i++) write_stop(i, pos_list[i], $urandom());
   endtask

   task automatic test_directed();
      configure(MODE_CLIP, 5'd16, 1);
      for (int i = 0; i < MAX_STOPS; i++)
         write_stop(i, -32768 + i * 4369, (i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000);
      map_sample(-32768);
      map_sample(32767);
      map_sample(-32768 + 4369);
      map_sample(-32768 + 2000);
      configure(MODE_REPEAT, 5'd16, 0);
      map_sample(-1);
      map_sample(4095);
      configure(MODE_MIRROR, 5'd16, 0);
      map_sample(-32768);
      map_sample(-5000);
      configure(MODE_DIVERGE, 5'd16, 0);
      map_sample(32767);
      map_sample(-32768);
      configure(MODE_CLIP, 5'd1, 0);
      map_sample(12345);
      configure(MODE_CLIP, 5'd0, 0);
      map_sample(-7);
      configure(MODE_CLIP, 5'd31, 0);
      map_sample(100);
   endtask

   task automatic test_equal_and_unsorted();
      configure(MODE_CLIP, 5'd4, 0);
      write_stop(0, -4096, 32'h0102_0304);
      write_stop(1, 0, 32'hFF00_FF00);
      write_stop(2, 0, 32'h00FF_00FF);
      write_stop(3, 4096, 32'h8080_8080);
      map_sample(0);
      map_sample(-1);
      map_sample(1);
      write_stop(1, 8000, 32'h1234_5678);
      write_stop(2, -8000, 32'h9ABC_DEF0);
      map_sample(-2000);
      map_sample(2000);
   endtask

   task automatic test_random_phases();
      int lo, hi, count, smp;
      for (int ph = 0; ph < 12; ph++) begin
         count = (ph < 2) ? (ph == 0 ? 16 : 2) : $urandom_range(0, 31);
         if ($urandom_range(0, 3) != 0 && (count < 2 || count > 16)) count = $urandom_range(2, 16);
         configure(2'($urandom_range(0, 3)), count[4:0], ph == 5);
         lo = $urandom_range(0, 40000);
         hi = lo + $urandom_range(50, 25535);
         load_sorted_table(lo, hi);
         for (int k = 0; k < 60; k++) begin
            if (ph == 3 && k == 30) wait_drained();
            case ($urandom_range(0, 19))
               0: write_stop($urandom_range(0, 15), $urandom(), $urandom());
               1: load_sorted_table(lo, hi);
               2, 3, 4, 5: map_sample($urandom());
               default: begin
                  smp = $urandom_range(lo, hi) - 32768;
                  if ($urandom_range(0, 1)) smp = smp / 2 - 2048;
                  map_sample(smp);
               end
            endcase
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_equal_and_unsorted();
      test_random_phases();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d stop writes and %0d mapped samples; %0d responses checked",
               writes_sent, maps_sent, colors_checked);
      $display("all four mapping modes, stop counts 0 to 31, equal and unsorted stops");
      if (error_count == 0 && pending_colors.size() == 0)
         $display("gradient_colormap_lookup verification clean");
      else
         $display("gradient_colormap_lookup verification failed");
      $finish;
   end

endmodule
